// ===== hdl/tmr_pkg.sv =====
// Package for the tilt motion reporter: word types, codes and constants.
package tmr_pkg;

   localparam int ACCEL_FRAC_BITS = 8;
   // Clamp limit of +-10 m/s^2 in fixed point.
   localparam int ACCEL_LIM       = 10 << ACCEL_FRAC_BITS;
   localparam int SMOOTH_ONE      = 256;
   localparam int POS_LEVEL       = 1000;
   localparam int POS_SCALE       = 100;
   localparam int POS_MAX         = 2000;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 40;

   typedef enum logic [1:0] {
      KIND_START    = 2'd0,
      KIND_STOP     = 2'd1,
      KIND_POSITION = 2'd2
   } report_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODE_BINARY        = 3'd0,
      REG_POSITION_THRESHOLD = 3'd1,
      REG_MOTION_THRESHOLD   = 3'd2,
      REG_SAMPLE_INTERVAL    = 3'd3,
      REG_INACTIVITY_TIMEOUT = 3'd4,
      REG_MIN_FRAME_GAP      = 3'd5,
      REG_SMOOTHING_FACTOR   = 3'd6,
      REG_TARGET_SERIAL      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic [31:0]        time_ms;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  report_kind;
      logic [10:0] position_x;
      logic [10:0] position_y;
      logic        last_of_run;
   } rsp_word_type;

endpackage

// ===== hdl/tilt_motion_reporter.sv =====
// Tilt motion reporter: sample smoother with motion events and tilt position reports.
//
// Usage:
//   Input words (accel_x, accel_y, time_ms) enter on the req_ channel, taken at an
//   edge where req_valid is high and req_stall is low. Result words leave on the
//   rsp_ channel, taken where rsp_valid is high and rsp_stall is low.
//   A word first lands in an input register; when the output side can take its
//   results, an edge runs the filter and compare logic and loads zero, one or two
//   results into a two-entry output buffer, whose head drives rsp_data.
//   Throughput is one input word per cycle while results are taken; a word that
//   yields two results fills the output buffer, and the next input word waits in
//   the input register (req_stall high) until the second result is being taken.
//   A stalled receiver keeps rsp_data steady; req_stall rises while the input
//   register holds a word that the output buffer cannot take.
//   Configuration registers are written through csr_wr_en / csr_index / csr_wdata
//   while the block is idle. Synchronous reset restores register defaults, resets
//   filter state and empties both buffers.
module tilt_motion_reporter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tmr_pkg::req_word_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tmr_pkg::rsp_word_type           rsp_data,
   input  logic                            csr_wr_en,
   input  logic [tmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tmr_pkg::*;

   // configuration
   logic        mode_binary_ff;
   logic [14:0] position_threshold_ff;
   logic [14:0] motion_threshold_ff;
   logic [15:0] sample_interval_ff;
   logic [31:0] inactivity_timeout_ff;
   logic [15:0] min_frame_gap_ff;
   logic [8:0]  smoothing_factor_ff;
   logic [39:0] target_serial_ff;

   // filter state
   logic [31:0]        last_accept_time_ff, last_accept_time_in;
   logic               primed_ff, primed_in;
   logic signed [15:0] smooth_x_ff, smooth_x_in;
   logic signed [15:0] smooth_y_ff, smooth_y_in;
   logic signed [15:0] reference_x_ff, reference_x_in;
   logic signed [15:0] reference_y_ff, reference_y_in;
   logic               moving_ff, moving_in;
   logic [31:0]        last_motion_time_ff, last_motion_time_in;
   logic [31:0]        last_report_time_ff, last_report_time_in;
   logic [11:0]        sent_x_ff, sent_x_in;
   logic [11:0]        sent_y_ff, sent_y_in;

   // input register and output buffer
   logic         in_vld_ff;
   req_word_type in_word_ff;
   logic [1:0]   out_cnt_ff, out_cnt_in;
   rsp_word_type slot0_ff, slot0_in;
   rsp_word_type slot1_ff, slot1_in;

   logic         fire;
   logic         pop;
   logic         req_take;
   logic [1:0]   res_n;
   rsp_word_type res0, res1;

   function automatic logic signed [15:0] smooth_step(input logic signed [15:0] s,
                                                      input logic signed [15:0] a,
                                                      input logic [8:0] f);
      logic signed [16:0] d;
      logic signed [26:0] p;
      logic signed [26:0] q;
      logic signed [26:0] sum;
      d   = {a[15], a} - {s[15], s};
      p   = d * $signed({1'b0, f});
      q   = p >>> 8;
      sum = {{11{s[15]}}, s} + q;
      return sum[15:0];
   endfunction

   function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
      logic signed [16:0] d;
      d = {a[15], a} - {b[15], b};
      return d[16] ? 17'(-d) : 17'(d);
   endfunction

   function automatic logic [10:0] to_position(input logic signed [15:0] v);
      logic signed [17:0] vc;
      logic [16:0]        mag;
      logic [23:0]        prod;
      logic [23:0]        shifted;
      logic [10:0]        m;
      vc = {{2{v[15]}}, v};
      if (vc > 18'(ACCEL_LIM)) begin
         vc = 18'(ACCEL_LIM);
      end else if (vc < -18'(ACCEL_LIM)) begin
         vc = -18'(ACCEL_LIM);
      end
      mag     = vc[17] ? 17'(-vc) : 17'(vc);
      prod    = {7'd0, mag} * 24'(POS_SCALE);
      shifted = prod >> ACCEL_FRAC_BITS;
      m       = shifted[10:0];
      return vc[17] ? 11'(POS_LEVEL) - m : 11'(POS_LEVEL) + m;
   endfunction

   assign pop       = (out_cnt_ff != 2'd0) && !rsp_stall;
   // process the held word only when the buffer will be empty this edge
   assign fire      = in_vld_ff && (out_cnt_ff == 2'd0 || (out_cnt_ff == 2'd1 && pop));
   assign req_stall = in_vld_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_binary_ff        <= 1'b0;
         position_threshold_ff <= 15'd256;
         motion_threshold_ff   <= 15'd256;
         sample_interval_ff    <= 16'd50;
         inactivity_timeout_ff <= 32'd1000;
         min_frame_gap_ff      <= 16'd70;
         smoothing_factor_ff   <= 9'd154;
         target_serial_ff      <= 40'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_MODE_BINARY:        mode_binary_ff        <= csr_wdata[0];
            REG_POSITION_THRESHOLD: position_threshold_ff <= csr_wdata[14:0];
            REG_MOTION_THRESHOLD:   motion_threshold_ff   <= csr_wdata[14:0];
            REG_SAMPLE_INTERVAL:    sample_interval_ff    <= csr_wdata[15:0];
            REG_INACTIVITY_TIMEOUT: inactivity_timeout_ff <= csr_wdata[31:0];
            REG_MIN_FRAME_GAP:      min_frame_gap_ff      <= csr_wdata[15:0];
            REG_SMOOTHING_FACTOR:   smoothing_factor_ff   <= csr_wdata[8:0];
            REG_TARGET_SERIAL:      target_serial_ff      <= csr_wdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [15:0] ax, ay;
      logic [31:0]        now;
      logic [8:0]         f;
      logic               mv, trig, start, stop, moving_mid;
      logic [31:0]        motion_mid;
      logic [10:0]        px, py;
      logic               report;

      ax  = in_word_ff.accel_x;
      ay  = in_word_ff.accel_y;
      now = in_word_ff.time_ms;
      f   = (smoothing_factor_ff > 9'(SMOOTH_ONE)) ? 9'(SMOOTH_ONE) : smoothing_factor_ff;

      last_accept_time_in = last_accept_time_ff;
      primed_in           = primed_ff;
      smooth_x_in         = smooth_x_ff;
      smooth_y_in         = smooth_y_ff;
      reference_x_in      = reference_x_ff;
      reference_y_in      = reference_y_ff;
      moving_in           = moving_ff;
      last_motion_time_in = last_motion_time_ff;
      last_report_time_in = last_report_time_ff;
      sent_x_in           = sent_x_ff;
      sent_y_in           = sent_y_ff;
      res_n               = 2'd0;
      res0                = '0;
      res1                = '0;

      mv         = 1'b0;
      trig       = 1'b0;
      start      = 1'b0;
      stop       = 1'b0;
      moving_mid = moving_ff;
      motion_mid = last_motion_time_ff;
      px         = to_position(smooth_x_in);
      py         = to_position(smooth_y_in);
      report     = 1'b0;

      // drop samples that come too soon
      if ((now - last_accept_time_ff) >= {16'd0, sample_interval_ff}) begin
         last_accept_time_in = now;
         if (!primed_ff) begin
            smooth_x_in    = ax;
            smooth_y_in    = ay;
            reference_x_in = ax;
            reference_y_in = ay;
            primed_in      = 1'b1;
         end else begin
            smooth_x_in = smooth_step(smooth_x_ff, ax, f);
            smooth_y_in = smooth_step(smooth_y_ff, ay, f);
            px          = to_position(smooth_x_in);
            py          = to_position(smooth_y_in);
            if (mode_binary_ff) begin
               mv = abs_diff(smooth_x_in, reference_x_ff) >= {2'd0, motion_threshold_ff} ||
                    abs_diff(smooth_y_in, reference_y_ff) >= {2'd0, motion_threshold_ff};
               start      = mv && !moving_ff;
               moving_mid = moving_ff || mv;
               motion_mid = mv ? now : last_motion_time_ff;
               stop       = moving_mid && ((now - motion_mid) >= inactivity_timeout_ff);
               moving_in           = moving_mid && !stop;
               last_motion_time_in = motion_mid;
               reference_x_in      = smooth_x_in;
               reference_y_in      = smooth_y_in;
               // start goes first when both occur
               if (start) begin
                  res0.report_kind = KIND_START;
                  res0.last_of_run = !stop;
                  res1.report_kind = KIND_STOP;
                  res1.last_of_run = 1'b1;
                  res_n            = stop ? 2'd2 : 2'd1;
               end else if (stop) begin
                  res0.report_kind = KIND_STOP;
                  res0.last_of_run = 1'b1;
                  res_n            = 2'd1;
               end
            end else begin
               trig = abs_diff(smooth_x_in, reference_x_ff) >= {2'd0, position_threshold_ff} ||
                      abs_diff(smooth_y_in, reference_y_ff) >= {2'd0, position_threshold_ff};
               report = trig && ((now - last_report_time_ff) >= {16'd0, min_frame_gap_ff}) &&
                        ({1'b0, px} != sent_x_ff || {1'b0, py} != sent_y_ff);
               if (report) begin
                  sent_x_in           = {1'b0, px};
                  sent_y_in           = {1'b0, py};
                  last_report_time_in = now;
                  last_motion_time_in = now;
                  reference_x_in      = smooth_x_in;
                  reference_y_in      = smooth_y_in;
                  // zero serial: update state, emit nothing
                  if (target_serial_ff != 40'd0) begin
                     res0.report_kind = KIND_POSITION;
                     res0.position_x  = px;
                     res0.position_y  = py;
                     res0.last_of_run = 1'b1;
                     res_n            = 2'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_accept_time_ff <= '0;
         primed_ff           <= 1'b0;
         smooth_x_ff         <= '0;
         smooth_y_ff         <= '0;
         reference_x_ff      <= '0;
         reference_y_ff      <= '0;
         moving_ff           <= 1'b0;
         last_motion_time_ff <= '0;
         last_report_time_ff <= '0;
         sent_x_ff           <= 12'hFFF;
         sent_y_ff           <= 12'hFFF;
      end else if (fire) begin
         last_accept_time_ff <= last_accept_time_in;
         primed_ff           <= primed_in;
         smooth_x_ff         <= smooth_x_in;
         smooth_y_ff         <= smooth_y_in;
         reference_x_ff      <= reference_x_in;
         reference_y_ff      <= reference_y_in;
         moving_ff           <= moving_in;
         last_motion_time_ff <= last_motion_time_in;
         last_report_time_ff <= last_report_time_in;
         sent_x_ff           <= sent_x_in;
         sent_y_ff           <= sent_y_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data;
      end
   end

   // output buffer: load on fire, else advance on pop
   always_comb begin
      out_cnt_in = out_cnt_ff;
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      if (fire) begin
         out_cnt_in = res_n;
         slot0_in   = res0;
         slot1_in   = res1;
      end else if (pop) begin
         out_cnt_in = out_cnt_ff - 2'd1;
         slot0_in   = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_not_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> out_cnt_ff == 2'd2)
      else $error("non-final result without a following word");

   a_fire_load: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_cnt_ff == $past(res_n))
      else $error("buffer load lost a pending word");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.report_kind == KIND_POSITION |->
         rsp_data.position_x <= 11'(POS_MAX) && rsp_data.position_y <= 11'(POS_MAX))
      else $error("position out of range");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && rsp_valid)
      else $error("input stalled with an empty output buffer");

endmodule

// ===== tb/tilt_motion_reporter_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the tilt motion reporter: directed sample plan, then random samples vs. a tracker.
module tilt_motion_reporter_tb;
   import tmr_pkg::*;

   localparam int SETTLE_CYCLES     = 4;
   localparam int HOLD_CYCLES       = 200;
   localparam int WORDS_PER_SETTING = 80;
   localparam int PRESSURE_WORDS    = 40;

   typedef struct packed {
      bit            is_write;
      csr_index_type reg_index;
      logic [39:0]   reg_value;
      req_word_type  word;
      bit            typed;
      logic [1:0]    typed_n;
      rsp_word_type  first;
      rsp_word_type  second;
   } plan_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   req_word_type           req_data  = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // register copies, at reset values
   bit          cfg_binary             = 1'b0;
   int          cfg_position_threshold = 256;
   int          cfg_motion_threshold   = 256;
   int          cfg_sample_interval    = 50;
   logic [31:0] cfg_inactivity_timeout = 32'd1000;
   int          cfg_min_frame_gap      = 70;
   int          cfg_smoothing_factor   = 154;
   logic [39:0] cfg_target_serial      = '0;

   // tracker state
   logic [31:0] last_accept_ms = '0;
   logic [31:0] last_motion_ms = '0;
   logic [31:0] last_report_ms = '0;
   bit          primed = 1'b0;
   bit          moving = 1'b0;
   int          smooth_x = 0, smooth_y = 0;
   int          ref_x = 0, ref_y = 0;
   int          sent_x = 4095, sent_y = 4095;

   rsp_word_type expected_reports[$];
   rsp_word_type staged_reports[$];
   plan_row_type directed_plan[$];

   int          sender_idle_pct   = 16;
   int          receiver_idle_pct = 76;
   bit          hold_request      = 1'b0;
   int          hold_left         = 0;
   bit          failed            = 1'b0;
   logic [31:0] stim_ms           = 32'h0000_0100;
   int          level_x = 0, level_y = 0;

   tilt_motion_reporter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic rsp_word_type make_report(report_kind_type kind, int px, int py, bit last);
      rsp_word_type r;
      r.report_kind = kind;
      r.position_x  = 11'(px);
      r.position_y  = 11'(py);
      r.last_of_run = last;
      return r;
   endfunction

   function automatic int abs_gap(int a, int b);
      return a >= b ? a - b : b - a;
   endfunction

   function automatic int tilt_position(int v);
      int m;
      if (v > ACCEL_LIM) v = ACCEL_LIM;
      if (v < -ACCEL_LIM) v = -ACCEL_LIM;
      m = ((v < 0 ? -v : v) * POS_SCALE) >>> ACCEL_FRAC_BITS;
      return v < 0 ? POS_LEVEL - m : POS_LEVEL + m;
   endfunction

   // Returns -1 for a sample dropped by the interval check, else the report count.
   function automatic int track_sample(req_word_type w);
      int          ax, ay, factor, px, py;
      logic [31:0] now;
      bit          mv, trig, start_ev, stop_ev;
      ax  = $signed(w.accel_x);
      ay  = $signed(w.accel_y);
      now = w.time_ms;
      if (now - last_accept_ms < cfg_sample_interval) return -1;
      last_accept_ms = now;
      if (!primed) begin
         smooth_x = ax;
         smooth_y = ay;
         ref_x    = ax;
         ref_y    = ay;
         primed   = 1'b1;
         return 0;
      end
      factor = cfg_smoothing_factor > SMOOTH_ONE ? SMOOTH_ONE : cfg_smoothing_factor;
      // floor divide by 256
      smooth_x = smooth_x + (((ax - smooth_x) * factor) >>> 8);
      smooth_y = smooth_y + (((ay - smooth_y) * factor) >>> 8);
      if (cfg_binary) begin
         mv = abs_gap(smooth_x, ref_x) >= cfg_motion_threshold ||
              abs_gap(smooth_y, ref_y) >= cfg_motion_threshold;
         start_ev = mv && !moving;
         if (start_ev) moving = 1'b1;
         if (mv) last_motion_ms = now;
         stop_ev = moving && (now - last_motion_ms >= cfg_inactivity_timeout);
         if (stop_ev) moving = 1'b0;
         ref_x = smooth_x;
         ref_y = smooth_y;
         if (start_ev) staged_reports.push_back(make_report(KIND_START, 0, 0, !stop_ev));
         if (stop_ev) staged_reports.push_back(make_report(KIND_STOP, 0, 0, 1'b1));
         return int'(start_ev) + int'(stop_ev);
      end
      trig = abs_gap(smooth_x, ref_x) >= cfg_position_threshold ||
             abs_gap(smooth_y, ref_y) >= cfg_position_threshold;
      if (!trig || now - last_report_ms < cfg_min_frame_gap) return 0;
      px = tilt_position(smooth_x);
      py = tilt_position(smooth_y);
      if (px == sent_x && py == sent_y) return 0;
      // a zero serial drops the word but the state moves on
      sent_x         = px;
      sent_y         = py;
      last_report_ms = now;
      last_motion_ms = now;
      ref_x          = smooth_x;
      ref_y          = smooth_y;
      if (cfg_target_serial == '0) return 0;
      staged_reports.push_back(make_report(KIND_POSITION, px, py, 1'b1));
      return 1;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin : take_reports
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected word kind %0d x %0d y %0d last %0d", $time,
                     rsp_data.report_kind, rsp_data.position_x, rsp_data.position_y,
                     rsp_data.last_of_run);
            failed = 1'b1;
         end else begin
            want = expected_reports.pop_front();
            check_field("report_kind", 32'(want.report_kind), 32'(rsp_data.report_kind));
            check_field("position_x", 32'(want.position_x), 32'(rsp_data.position_x));
            check_field("position_y", 32'(want.position_y), 32'(rsp_data.position_y));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_data.last_of_run));
         end
      end
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   function automatic void plan_write(csr_index_type idx, logic [39:0] value);
      plan_row_type row;
      row           = '0;
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = value;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_sample(int x, int y, logic [31:0] t, bit typed, int n,
                                       rsp_word_type first, rsp_word_type second);
      plan_row_type row;
      row              = '0;
      row.word.accel_x = 16'(x);
      row.word.accel_y = 16'(y);
      row.word.time_ms = t;
      row.typed        = typed;
      row.typed_n      = 2'(n);
      row.first        = first;
      row.second       = second;
      directed_plan.push_back(row);
   endfunction

   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic offer_sample(req_word_type w, output int n);
      send_word(w);
      n = track_sample(w);
      while (staged_reports.size() != 0) expected_reports.push_back(staged_reports.pop_front());
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      // a dropped or silent word may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [39:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_MODE_BINARY:        cfg_binary             = value[0];
         REG_POSITION_THRESHOLD: cfg_position_threshold = int'(value[14:0]);
         REG_MOTION_THRESHOLD:   cfg_motion_threshold   = int'(value[14:0]);
         REG_SAMPLE_INTERVAL:    cfg_sample_interval    = int'(value[15:0]);
         REG_INACTIVITY_TIMEOUT: cfg_inactivity_timeout = value[31:0];
         REG_MIN_FRAME_GAP:      cfg_min_frame_gap      = int'(value[15:0]);
         REG_SMOOTHING_FACTOR:   cfg_smoothing_factor   = int'(value[8:0]);
         REG_TARGET_SERIAL:      cfg_target_serial      = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(int k);
      bit          binary;
      int          pos_thr, mot_thr, interval, gap, factor;
      logic [31:0] timeout;
      logic [39:0] serial;
      drain_reports();
      case (k)
         1: begin
            binary = 1'b1; pos_thr = 0; mot_thr = 0; interval = 0;
            timeout = '0; gap = 0; factor = 0; serial = '0;
         end
         4: begin
            binary = 1'b0; pos_thr = 32767; mot_thr = 32767; interval = 65535;
            timeout = '1; gap = 65535; factor = 511; serial = '1;
         end
         7: begin
            binary = 1'b0; pos_thr = 0; mot_thr = $urandom_range(800); interval = 0;
            timeout = $urandom_range(600); gap = 0; factor = SMOOTH_ONE;
            serial = {8'($urandom), 32'($urandom)} | 40'd1;
         end
         default: begin
            binary   = 1'($urandom_range(1));
            pos_thr  = $urandom_range(800);
            mot_thr  = $urandom_range(800);
            interval = $urandom_range(120);
            gap      = $urandom_range(150);
            factor   = $urandom_range(511);
            case ($urandom_range(9))
               0:       timeout = '0;
               1:       timeout = '1;
               default: timeout = $urandom_range(600);
            endcase
            case ($urandom_range(4))
               0:       serial = '0;
               1:       serial = '1;
               default: serial = {8'($urandom), 32'($urandom)};
            endcase
         end
      endcase
      write_reg(REG_MODE_BINARY, 40'(binary));
      write_reg(REG_POSITION_THRESHOLD, 40'(pos_thr));
      write_reg(REG_MOTION_THRESHOLD, 40'(mot_thr));
      write_reg(REG_SAMPLE_INTERVAL, 40'(interval));
      write_reg(REG_INACTIVITY_TIMEOUT, 40'(timeout));
      write_reg(REG_MIN_FRAME_GAP, 40'(gap));
      write_reg(REG_SMOOTHING_FACTOR, 40'(factor));
      write_reg(REG_TARGET_SERIAL, serial);
   endtask

   // Mostly steady levels with noise, some level jumps, some raw words.
   function automatic req_word_type next_sample();
      req_word_type w;
      int           r;
      r = $urandom_range(99);
      if (r < 10) stim_ms = stim_ms + $urandom_range(cfg_sample_interval);
      else if (r < 18) stim_ms = stim_ms + $urandom;
      else stim_ms = stim_ms + cfg_sample_interval + $urandom_range(120);
      w.time_ms = stim_ms;
      r = $urandom_range(99);
      if (r < 12) begin
         w.accel_x = 16'($urandom);
         w.accel_y = 16'($urandom);
      end else begin
         if (r < 30) begin
            level_x = int'($urandom_range(12000)) - 6000;
            level_y = int'($urandom_range(12000)) - 6000;
         end
         w.accel_x = 16'(level_x + int'($urandom_range(800)) - 400);
         w.accel_y = 16'(level_y + int'($urandom_range(800)) - 400);
      end
      return w;
   endfunction

   initial begin : stimulus
      plan_row_type row;
      req_word_type w;
      rsp_word_type none;
      int           n, counted;

      none = '0;
      // zero serial: nothing comes out, state still moves
      plan_sample(0, 0, 32'd0, 1'b1, 0, none, none);
      plan_sample(32767, -32768, 32'd100, 1'b0, 0, none, none);
      plan_sample(-32768, 32767, 32'd120, 1'b1, 0, none, none);
      plan_sample(-32768, 32767, 32'd150, 1'b0, 0, none, none);
      plan_write(REG_TARGET_SERIAL, 40'h01_0000_0001);
      plan_write(REG_SMOOTHING_FACTOR, 40'd256);
      plan_sample(32767, -32768, 32'd300, 1'b1, 1,
                  make_report(KIND_POSITION, 2000, 0, 1'b1), none);
      plan_sample(0, 0, 32'd400, 1'b1, 1, make_report(KIND_POSITION, 1000, 1000, 1'b1), none);
      plan_sample(0, 0, 32'd401, 1'b1, 0, none, none);
      plan_sample(256, -256, 32'd460, 1'b1, 0, none, none);
      plan_sample(256, -256, 32'd520, 1'b1, 1,
                  make_report(KIND_POSITION, 1100, 900, 1'b1), none);
      plan_sample(1, -1, 32'd600, 1'b1, 0, none, none);
      plan_sample(-2560, 2560, 32'd700, 1'b1, 1,
                  make_report(KIND_POSITION, 0, 2000, 1'b1), none);
      plan_sample(-2560, 2560, 32'd800, 1'b1, 0, none, none);
      plan_write(REG_MODE_BINARY, 40'd1);
      plan_write(REG_INACTIVITY_TIMEOUT, 40'd0);
      // zero timeout: start and stop from one sample
      plan_sample(0, 0, 32'd900, 1'b1, 2, make_report(KIND_START, 0, 0, 1'b0),
                  make_report(KIND_STOP, 0, 0, 1'b1));
      plan_sample(0, 0, 32'd1000, 1'b1, 0, none, none);
      plan_write(REG_INACTIVITY_TIMEOUT, 40'd100);
      plan_sample(1000, 0, 32'd1100, 1'b1, 1, make_report(KIND_START, 0, 0, 1'b1), none);
      plan_sample(1000, 0, 32'd1150, 1'b1, 0, none, none);
      plan_sample(1000, 0, 32'd1200, 1'b1, 1, make_report(KIND_STOP, 0, 0, 1'b1), none);
      // timestamps wrap past 2^32
      plan_sample(0, 0, 32'hFFFF_FFF0, 1'b1, 1, make_report(KIND_START, 0, 0, 1'b1), none);
      plan_sample(0, 0, 32'h0000_0040, 1'b1, 0, none, none);
      plan_sample(0, 0, 32'h0000_00A0, 1'b1, 1, make_report(KIND_STOP, 0, 0, 1'b1), none);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.is_write) begin
            drain_reports();
            write_reg(row.reg_index, row.reg_value);
         end else if (row.typed) begin
            send_word(row.word);
            n = track_sample(row.word);
            staged_reports.delete();
            if (row.typed_n > 0) expected_reports.push_back(row.first);
            if (row.typed_n > 1) expected_reports.push_back(row.second);
         end else begin
            offer_sample(row.word, n);
         end
      end

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin sender_idle_pct = 16; receiver_idle_pct = 76; end
            1: begin sender_idle_pct = 76; receiver_idle_pct = 16; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         endcase
         for (int s = 0; s < 3; s++) begin
            apply_setting(p * 3 + s);
            counted = 0;
            while (counted < WORDS_PER_SETTING) begin
               w = next_sample();
               offer_sample(w, n);
               if (n >= 0) counted++;
            end
         end
      end

      // back up the output side while words keep coming: each one starts and stops
      drain_reports();
      write_reg(REG_MODE_BINARY, 40'd1);
      write_reg(REG_MOTION_THRESHOLD, 40'd16);
      write_reg(REG_INACTIVITY_TIMEOUT, 40'd0);
      write_reg(REG_SAMPLE_INTERVAL, 40'd0);
      write_reg(REG_SMOOTHING_FACTOR, 40'd256);
      hold_request = 1'b1;
      for (int i = 0; i < PRESSURE_WORDS; i++) begin
         stim_ms   = stim_ms + 1;
         w.time_ms = stim_ms;
         w.accel_x = 16'((i % 2) * 2048 + int'($urandom_range(15)));
         w.accel_y = 16'(-((i % 2) * 2048) - int'($urandom_range(15)));
         offer_sample(w, n);
      end

      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!failed) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
